// File: rtl/stick_radial_deadzone_scaler_macros.svh
// Assertion macros shared by the block.
`ifndef STICK_RADIAL_DEADZONE_SCALER_MACROS_SVH
`define STICK_RADIAL_DEADZONE_SCALER_MACROS_SVH
`ifndef ASSERT_OFF
`define SRDS_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define SRDS_ASSERT_ALWAYS(label, clk, rst_n, a) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a)) \
		else $error("assertion failed");
`else
`define SRDS_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define SRDS_ASSERT_ALWAYS(label, clk, rst_n, a)
`endif
`endif

// File: rtl/srds_pkg.sv
package srds_pkg;
	localparam logic [14:0] FullScale = 15'd32767;
	localparam logic [14:0] DeadMax = 15'd32766;
	localparam int SqrtStages = 16;
	localparam int DivStages = 16;

	typedef struct packed {
		logic [15:0] mx;
		logic [15:0] my;
		logic nx;
		logic ny;
	} mag_t;

	typedef struct packed {
		logic [45:0] num;
		logic neg;
	} lane_t;

	typedef struct packed {
		lane_t lx;
		lane_t ly;
		logic [29:0] den;
		logic zero;
	} div_in_t;
endpackage

// File: rtl/srds_front.sv
module srds_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [15:0] stick_x,
	input logic signed [15:0] stick_y,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] sq,
	output srds_pkg::mag_t mag
);
	import srds_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic r1, r2, r3;
	mag_t mag_s1, mag_s2, mag_s3;
	logic [31:0] sqx_s2, sqy_s2, sq_s3;
	mag_t mag_in;

	assign r3 = !v_s3 || out_ready;
	assign r2 = !v_s2 || r3;
	assign r1 = !v_s1 || r2;
	assign in_ready = r1;
	assign out_valid = v_s3;
	assign sq = sq_s3;
	assign mag = mag_s3;

	always_comb begin
		mag_in.nx = stick_x[15];
		mag_in.ny = stick_y[15];
		mag_in.mx = stick_x[15] ? (16'd0 - stick_x) : stick_x;
		mag_in.my = stick_y[15] ? (16'd0 - stick_y) : stick_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (r1) v_s1 <= in_valid;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (r1) mag_s1 <= mag_in;
		if (r2) begin
			mag_s2 <= mag_s1;
			sqx_s2 <= mag_s1.mx * mag_s1.mx;
			sqy_s2 <= mag_s1.my * mag_s1.my;
		end
		if (r3) begin
			mag_s3 <= mag_s2;
			sq_s3 <= sqx_s2 + sqy_s2;
		end
	end
endmodule

// File: rtl/srds_sqrt.sv
module srds_sqrt (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [31:0] sq,
	input srds_pkg::mag_t mag_in,
	output logic out_valid,
	input logic out_ready,
	output logic [15:0] radius,
	output srds_pkg::mag_t mag_out
);
	import srds_pkg::*;

	logic [SqrtStages-1:0] v_s;
	logic [SqrtStages:0] rdy;
	logic [31:0] rem_s [SqrtStages];
	logic [31:0] res_s [SqrtStages];
	mag_t mag_s [SqrtStages];
	logic [31:0] rem_n [SqrtStages];
	logic [31:0] res_n [SqrtStages];

	assign in_ready = rdy[0];
	assign out_valid = v_s[SqrtStages-1];
	assign radius = res_s[SqrtStages-1][15:0];
	assign mag_out = mag_s[SqrtStages-1];

	always_comb begin
		logic [31:0] rem_p, res_p, bitv, trial;
		rdy[SqrtStages] = out_ready;
		for (int k = SqrtStages - 1; k >= 0; k--) begin
			rdy[k] = !v_s[k] || rdy[k+1];
		end
		for (int k = 0; k < SqrtStages; k++) begin
			rem_p = (k == 0) ? sq : rem_s[(k == 0) ? 0 : k-1];
			res_p = (k == 0) ? 32'd0 : res_s[(k == 0) ? 0 : k-1];
			bitv = 32'd1 << (30 - 2 * k);
			trial = res_p + bitv;
			if (rem_p >= trial) begin
				rem_n[k] = rem_p - trial;
				res_n[k] = (res_p >> 1) + bitv;
			end else begin
				rem_n[k] = rem_p;
				res_n[k] = res_p >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int k = 0; k < SqrtStages; k++) begin
				if (rdy[k]) v_s[k] <= (k == 0) ? in_valid : v_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < SqrtStages; k++) begin
			if (rdy[k]) begin
				rem_s[k] <= rem_n[k];
				res_s[k] <= res_n[k];
				mag_s[k] <= (k == 0) ? mag_in : mag_s[(k == 0) ? 0 : k-1];
			end
		end
	end
endmodule

// File: rtl/srds_scale.sv
module srds_scale (
	input logic clk,
	input logic arst_n,
	input logic [14:0] dead_radius,
	input logic in_valid,
	output logic in_ready,
	input logic [15:0] radius,
	input srds_pkg::mag_t mag,
	output logic out_valid,
	input logic out_ready,
	output srds_pkg::div_in_t div_in
);
	import srds_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic r1, r2, r3;
	logic [14:0] rc, rc_s1, diff_s1, dd_s1;
	logic zero_s1, zero_s2;
	mag_t mag_s1, mag_s2;
	logic [30:0] pa_s2, pb_s2;
	logic [29:0] den_s2;
	div_in_t out_s3;

	assign r3 = !v_s3 || out_ready;
	assign r2 = !v_s2 || r3;
	assign r1 = !v_s1 || r2;
	assign in_ready = r1;
	assign out_valid = v_s3;
	assign div_in = out_s3;
	assign rc = (radius > {1'b0, FullScale}) ? FullScale : radius[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (r1) v_s1 <= in_valid;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (r1) begin
			rc_s1 <= rc;
			zero_s1 <= (rc < dead_radius) || (rc == 15'd0);
			diff_s1 <= rc - dead_radius;
			dd_s1 <= FullScale - dead_radius;
			mag_s1 <= mag;
		end
		if (r2) begin
			zero_s2 <= zero_s1;
			mag_s2 <= mag_s1;
			pa_s2 <= diff_s1 * mag_s1.mx;
			pb_s2 <= diff_s1 * mag_s1.my;
			den_s2 <= dd_s1 * rc_s1;
		end
		if (r3) begin
			out_s3.lx.num <= {pa_s2, 15'd0} - {15'd0, pa_s2};
			out_s3.ly.num <= {pb_s2, 15'd0} - {15'd0, pb_s2};
			out_s3.lx.neg <= mag_s2.nx;
			out_s3.ly.neg <= mag_s2.ny;
			out_s3.den <= den_s2;
			out_s3.zero <= zero_s2;
		end
	end
endmodule

// File: rtl/srds_div.sv
module srds_div (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input srds_pkg::div_in_t div_in,
	output logic out_valid,
	input logic out_ready,
	output logic [15:0] qx,
	output logic [15:0] qy,
	output logic negx,
	output logic negy,
	output logic zero
);
	import srds_pkg::*;

	logic [DivStages-1:0] v_s;
	logic [DivStages:0] rdy;
	div_in_t d_s [DivStages];
	logic [15:0] qx_s [DivStages];
	logic [15:0] qy_s [DivStages];
	div_in_t d_n [DivStages];
	logic [15:0] qx_n [DivStages];
	logic [15:0] qy_n [DivStages];

	assign in_ready = rdy[0];
	assign out_valid = v_s[DivStages-1];
	assign qx = qx_s[DivStages-1];
	assign qy = qy_s[DivStages-1];
	assign negx = d_s[DivStages-1].lx.neg;
	assign negy = d_s[DivStages-1].ly.neg;
	assign zero = d_s[DivStages-1].zero;

	always_comb begin
		div_in_t dp;
		logic [15:0] qxp, qyp;
		logic [45:0] trial;
		rdy[DivStages] = out_ready;
		for (int k = DivStages - 1; k >= 0; k--) begin
			rdy[k] = !v_s[k] || rdy[k+1];
		end
		for (int k = 0; k < DivStages; k++) begin
			dp = (k == 0) ? div_in : d_s[(k == 0) ? 0 : k-1];
			qxp = (k == 0) ? 16'd0 : qx_s[(k == 0) ? 0 : k-1];
			qyp = (k == 0) ? 16'd0 : qy_s[(k == 0) ? 0 : k-1];
			trial = {16'd0, dp.den} << (DivStages - 1 - k);
			d_n[k] = dp;
			qx_n[k] = qxp;
			qy_n[k] = qyp;
			if (dp.lx.num >= trial) begin
				d_n[k].lx.num = dp.lx.num - trial;
				qx_n[k][DivStages-1-k] = 1'b1;
			end
			if (dp.ly.num >= trial) begin
				d_n[k].ly.num = dp.ly.num - trial;
				qy_n[k][DivStages-1-k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int k = 0; k < DivStages; k++) begin
				if (rdy[k]) v_s[k] <= (k == 0) ? in_valid : v_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DivStages; k++) begin
			if (rdy[k]) begin
				d_s[k] <= d_n[k];
				qx_s[k] <= qx_n[k];
				qy_s[k] <= qy_n[k];
			end
		end
	end
endmodule

// File: rtl/stick_radial_deadzone_scaler.sv
// Scaled radial deadzone for one thumbstick sample.
// A request on the input channel (in_valid/in_ready) carries stick_x and
// stick_y as signed 16-bit positions. Each request produces exactly one
// request on the output channel (out_valid/out_ready) with out_x and out_y,
// rescaled so the deadzone edge maps to zero and full deflection to 32767.
// The deadzone radius is written through cfg_valid/cfg_ready/cfg_data and
// saturates to 32766; write it only while the block is idle.
// Samples pass through squaring, the radius square root, the scale products,
// the restoring dividers and the output register. The pipeline accepts one
// sample every cycle while no stalled receiver backs it up to the input.
// Each stage holds its own valid bit, so a stalled receiver backs up only
// the stages that are full; empty stages keep accepting requests.
// Reset clears all valid bits and sets the deadzone radius to zero.
module stick_radial_deadzone_scaler (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [14:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic signed [15:0] stick_x,
	input logic signed [15:0] stick_y,
	output logic out_valid,
	input logic out_ready,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y
);
	import srds_pkg::*;
	`include "stick_radial_deadzone_scaler_macros.svh"

	logic [14:0] dead_radius_q;
	logic f_valid, f_ready, s_valid, s_ready, c_valid, c_ready, d_valid, d_ready;
	logic [31:0] sq;
	mag_t f_mag, s_mag;
	logic [15:0] radius;
	div_in_t div_in;
	logic [15:0] qx, qy, cx, cy;
	logic negx, negy, zero;
	logic out_valid_q;
	logic signed [15:0] out_x_q, out_y_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_radius_q <= 15'd0;
		end else if (cfg_valid) begin
			dead_radius_q <= (cfg_data > DeadMax) ? DeadMax : cfg_data;
		end
	end

	srds_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.stick_x(stick_x), .stick_y(stick_y),
		.out_valid(f_valid), .out_ready(f_ready),
		.sq(sq), .mag(f_mag)
	);

	srds_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready),
		.sq(sq), .mag_in(f_mag),
		.out_valid(s_valid), .out_ready(s_ready),
		.radius(radius), .mag_out(s_mag)
	);

	srds_scale u_scale (
		.clk(clk), .arst_n(arst_n), .dead_radius(dead_radius_q),
		.in_valid(s_valid), .in_ready(s_ready),
		.radius(radius), .mag(s_mag),
		.out_valid(c_valid), .out_ready(c_ready),
		.div_in(div_in)
	);

	srds_div u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(c_valid), .in_ready(c_ready),
		.div_in(div_in),
		.out_valid(d_valid), .out_ready(d_ready),
		.qx(qx), .qy(qy), .negx(negx), .negy(negy), .zero(zero)
	);

	assign d_ready = !out_valid_q || out_ready;
	assign cx = (qx > {1'b0, FullScale}) ? {1'b0, FullScale} : qx;
	assign cy = (qy > {1'b0, FullScale}) ? {1'b0, FullScale} : qy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (d_ready) begin
			out_valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (d_ready) begin
			out_x_q <= zero ? 16'sd0 : (negx ? $signed(16'd0 - cx) : $signed(cx));
			out_y_q <= zero ? 16'sd0 : (negy ? $signed(16'd0 - cy) : $signed(cy));
		end
	end

	assign out_valid = out_valid_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;

	`SRDS_ASSERT_ALWAYS(a_dead_max, clk, arst_n, dead_radius_q <= DeadMax)
	`SRDS_ASSERT_IMPLIES(a_out_x_range, clk, arst_n, out_valid, out_x != 16'sh8000)
	`SRDS_ASSERT_IMPLIES(a_out_y_range, clk, arst_n, out_valid, out_y != 16'sh8000)
endmodule
